[design/rrso_pkg.sv]
// Package for the rectangle overlap core: coordinate, axis, product and dot-product types,
// the item opcodes and the lane control struct.
// No dependencies; every other design file uses it by scoped names.
package rrso_pkg;

   // Width of one corner coordinate (Q12.4 at the default width).
   localparam int COORD_W = 16;
   // An axis is the difference of two coordinates.
   localparam int AXIS_W  = COORD_W + 1;
   // A coordinate times an axis component.
   localparam int PROD_W  = COORD_W + AXIS_W;
   // The sum of two products.
   localparam int DOT_W   = PROD_W + 1;

   // Number of separating axes, one lane each.
   localparam int NUM_LANES = 4;

   // Item opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [AXIS_W-1:0]  axis_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;

   // Four corners: x1, y1, x2, y2, x3, y3, x4, y4 at indexes 0 to 7.
   typedef logic [7:0][COORD_W-1:0] rect_type;

   // Load enables for the stages that live inside a lane.
   typedef struct packed {
      logic prod_en;
      logic dot_en;
      logic span_en;
   } lane_ctrl_type;

endpackage

[design/rrso_lane.sv]
// One axis lane of the rectangle overlap core: projects all eight corners onto one axis,
// finds both rectangles' projection intervals and checks that they meet.
// Depends on rrso_pkg.
module rrso_lane (
   input  logic                    clock,
   input  rrso_pkg::lane_ctrl_type ctrl,
   input  rrso_pkg::axis_type      axis_x,
   input  rrso_pkg::axis_type      axis_y,
   input  rrso_pkg::rect_type      ref_rect,
   input  rrso_pkg::rect_type      test_rect,
   output logic                    meets
);

   function automatic rrso_pkg::dot_type dot_min(rrso_pkg::dot_type a, rrso_pkg::dot_type b);
      return (b < a) ? b : a;
   endfunction

   function automatic rrso_pkg::dot_type dot_max(rrso_pkg::dot_type a, rrso_pkg::dot_type b);
      return (a < b) ? b : a;
   endfunction

   rrso_pkg::coord_type cx [8];
   rrso_pkg::coord_type cy [8];
   rrso_pkg::prod_type  px_in [8];
   rrso_pkg::prod_type  py_in [8];
   rrso_pkg::prod_type  px_ff [8];
   rrso_pkg::prod_type  py_ff [8];
   rrso_pkg::dot_type   dot_in [8];
   rrso_pkg::dot_type   dot_ff [8];
   rrso_pkg::dot_type   rlo_in, rhi_in, tlo_in, thi_in;
   rrso_pkg::dot_type   rlo_ff, rhi_ff, tlo_ff, thi_ff;

   // Corners 0 to 3 are the reference rectangle, 4 to 7 the test rectangle.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cx[i]   = $signed(ref_rect[2*i]);
         cy[i]   = $signed(ref_rect[2*i+1]);
         cx[i+4] = $signed(test_rect[2*i]);
         cy[i+4] = $signed(test_rect[2*i+1]);
      end
   end

   // Multiplier stage: each corner coordinate times its axis component.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         px_in[i] = rrso_pkg::prod_type'(cx[i]) * rrso_pkg::prod_type'(axis_x);
         py_in[i] = rrso_pkg::prod_type'(cy[i]) * rrso_pkg::prod_type'(axis_y);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // Adder stage: the full-precision dot product of each corner.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         dot_in[i] = rrso_pkg::dot_type'(px_ff[i]) + rrso_pkg::dot_type'(py_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.dot_en) begin
         dot_ff <= dot_in;
      end
   end

   // Interval stage: two-level min and max trees per rectangle.
   always_comb begin
      rlo_in = dot_min(dot_min(dot_ff[0], dot_ff[1]), dot_min(dot_ff[2], dot_ff[3]));
      rhi_in = dot_max(dot_max(dot_ff[0], dot_ff[1]), dot_max(dot_ff[2], dot_ff[3]));
      tlo_in = dot_min(dot_min(dot_ff[4], dot_ff[5]), dot_min(dot_ff[6], dot_ff[7]));
      thi_in = dot_max(dot_max(dot_ff[4], dot_ff[5]), dot_max(dot_ff[6], dot_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (ctrl.span_en) begin
         rlo_ff <= rlo_in;
         rhi_ff <= rhi_in;
         tlo_ff <= tlo_in;
         thi_ff <= thi_in;
      end
   end

   // Closed intervals meet unless one lies wholly below the other.
   assign meets = !(thi_ff < rlo_ff) && !(rhi_ff < tlo_ff);

endmodule

[design/rrso_merge.sv]
// Merging stage of the rectangle overlap core: combines the lane verdicts into the
// registered overlap flag of the result item.
// Depends on rrso_pkg.
module rrso_merge (
   input  logic                           clock,
   input  logic                           load_en,
   input  logic [rrso_pkg::NUM_LANES-1:0] lane_meets,
   output logic                           overlaps
);

   logic overlaps_ff;
   logic overlaps_in;

   // The rectangles overlap only when no axis separates them.
   assign overlaps_in = &lane_meets;

   always_ff @(posedge clock) begin
      if (load_en) begin
         overlaps_ff <= overlaps_in;
      end
   end

   assign overlaps = overlaps_ff;

endmodule

[design/rect_rect_sat_overlap_core.sv]
// Top level of the rectangle overlap core, the axis stage and the pipeline control.
// Depends on rrso_pkg, rrso_lane and rrso_merge.
//
// Separating axis overlap test for two oriented rectangles in signed Q12.4 corners. A load
// item (opcode 0) stores the reference rectangle in the accepted cycle and gives no result;
// a test item (opcode 1) gives one result, overlaps = 1 when the rectangles intersect or
// touch. The core accepts one item per clock cycle while req_stall is low. A test item's
// result is formed over five register stages: an axis stage, then in each of four
// parallel axis lanes a multiplier stage (sixteen multipliers per lane), a dot-product add
// stage and a min/max stage, then the merge stage that holds the result register. Each test
// item carries its own copy of the reference, so a load that follows a test never changes
// that test's answer. Stages advance independently, so bubbles are filled while rsp_stall is
// high; req_stall rises only when every stage holds a waiting result. The reference is all
// zero after reset.
module rect_rect_sat_overlap_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner1_x,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner1_y,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner2_x,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner2_y,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner3_x,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner3_y,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner4_x,
   input  logic [rrso_pkg::COORD_W-1:0] req_corner4_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_overlaps
);

   rrso_pkg::rect_type req_rect;
   rrso_pkg::rect_type ref_ff;
   rrso_pkg::rect_type ref_in;
   rrso_pkg::rect_type ref_copy_ff;
   rrso_pkg::rect_type test_ff;
   rrso_pkg::axis_type ax_in [rrso_pkg::NUM_LANES];
   rrso_pkg::axis_type ay_in [rrso_pkg::NUM_LANES];
   rrso_pkg::axis_type ax_ff [rrso_pkg::NUM_LANES];
   rrso_pkg::axis_type ay_ff [rrso_pkg::NUM_LANES];
   logic [5:1]         vld_ff;
   logic [5:1]         vld_in;
   logic [5:1]         rdy;
   logic               req_accept;
   rrso_pkg::lane_ctrl_type      lane_ctrl;
   logic [rrso_pkg::NUM_LANES-1:0] lane_meets;

   // Gather the corner ports in model order.
   always_comb begin
      req_rect[0] = req_corner1_x;
      req_rect[1] = req_corner1_y;
      req_rect[2] = req_corner2_x;
      req_rect[3] = req_corner2_y;
      req_rect[4] = req_corner3_x;
      req_rect[5] = req_corner3_y;
      req_rect[6] = req_corner4_x;
      req_rect[7] = req_corner4_y;
   end

   // A stage may load when it is empty or its item moves on in the same cycle.
   always_comb begin
      rdy[5] = !vld_ff[5] || !rsp_stall;
      rdy[4] = !vld_ff[4] || rdy[5];
      rdy[3] = !vld_ff[3] || rdy[4];
      rdy[2] = !vld_ff[2] || rdy[3];
      rdy[1] = !vld_ff[1] || rdy[2];
   end

   assign req_stall  = !rdy[1];
   assign req_accept = req_valid && rdy[1];

   // Only test items travel down the pipeline.
   always_comb begin
      vld_in[1] = rdy[1] ? (req_accept && (req_opcode == rrso_pkg::OP_TEST)) : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = rdy[3] ? vld_ff[2] : vld_ff[3];
      vld_in[4] = rdy[4] ? vld_ff[3] : vld_ff[4];
      vld_in[5] = rdy[5] ? vld_ff[4] : vld_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Reference rectangle, replaced by each load item.
   assign ref_in = (req_accept && (req_opcode == rrso_pkg::OP_LOAD)) ? req_rect : ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else begin
         ref_ff <= ref_in;
      end
   end

   // Axis stage: edges a2-a1 and a4-a2 of the reference, then of the test rectangle.
   always_comb begin
      ax_in[0] = rrso_pkg::axis_type'($signed(ref_ff[2])) -
                 rrso_pkg::axis_type'($signed(ref_ff[0]));
      ay_in[0] = rrso_pkg::axis_type'($signed(ref_ff[3])) -
                 rrso_pkg::axis_type'($signed(ref_ff[1]));
      ax_in[1] = rrso_pkg::axis_type'($signed(ref_ff[6])) -
                 rrso_pkg::axis_type'($signed(ref_ff[2]));
      ay_in[1] = rrso_pkg::axis_type'($signed(ref_ff[7])) -
                 rrso_pkg::axis_type'($signed(ref_ff[3]));
      ax_in[2] = rrso_pkg::axis_type'($signed(req_rect[2])) -
                 rrso_pkg::axis_type'($signed(req_rect[0]));
      ay_in[2] = rrso_pkg::axis_type'($signed(req_rect[3])) -
                 rrso_pkg::axis_type'($signed(req_rect[1]));
      ax_in[3] = rrso_pkg::axis_type'($signed(req_rect[6])) -
                 rrso_pkg::axis_type'($signed(req_rect[2]));
      ay_in[3] = rrso_pkg::axis_type'($signed(req_rect[7])) -
                 rrso_pkg::axis_type'($signed(req_rect[3]));
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ax_ff       <= ax_in;
         ay_ff       <= ay_in;
         test_ff     <= req_rect;
         ref_copy_ff <= ref_ff;
      end
   end

   // Stage enables for the lanes.
   always_comb begin
      lane_ctrl.prod_en = rdy[2];
      lane_ctrl.dot_en  = rdy[3];
      lane_ctrl.span_en = rdy[4];
   end

   // One lane per candidate separating axis.
   for (genvar g = 0; g < rrso_pkg::NUM_LANES; g++) begin : g_lane
      rrso_lane u_lane (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .axis_x    (ax_ff[g]),
         .axis_y    (ay_ff[g]),
         .ref_rect  (ref_copy_ff),
         .test_rect (test_ff),
         .meets     (lane_meets[g])
      );
   end

   // Merge the lane verdicts into the result register.
   rrso_merge u_merge (
      .clock      (clock),
      .load_en    (rdy[5]),
      .lane_meets (lane_meets),
      .overlaps   (rsp_overlaps)
   );

   assign rsp_valid = vld_ff[5];

endmodule
